>>> hw/rtl/lbrf_pkg.sv
// ----------------------------------------------------------------------------
// lbrf_pkg: shared types and constants for the lidar beam range filter
// Beam and result payloads, configuration set, register indexes, resets.
// ----------------------------------------------------------------------------
package lbrf_pkg;

  localparam int unsigned MM_W = 16;
  localparam int unsigned INT_W = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // result queue; depth must be a power of two (pointers wrap naturally)
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MM_W-1:0] DELTA_THRESHOLD_RST = 16'd30;
  localparam logic [MM_W-1:0] HEAD_LIMIT_RST = 16'd300;
  localparam logic [MM_W-1:0] NEAR_LIMIT_RST = 16'd2000;
  localparam logic [INT_W-1:0] INTENSITY_FLOOR_RST = 16'd2000;
  localparam logic [MM_W-1:0] FAR_VALUE_RST = 16'd60000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELTA_THRESHOLD = 3'd0,
    REG_HEAD_LIMIT      = 3'd1,
    REG_NEAR_LIMIT      = 3'd2,
    REG_INTENSITY_FLOOR = 3'd3,
    REG_FAR_VALUE       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [MM_W-1:0]  range_mm;
    logic [INT_W-1:0] intensity;
    logic             last_beam;
  } beam_t;

  typedef struct packed {
    logic [MM_W-1:0] filtered_mm;
    logic            scan_end;
  } result_t;

  typedef struct packed {
    logic [MM_W-1:0]  delta_threshold;
    logic [MM_W-1:0]  head_limit;
    logic [MM_W-1:0]  near_limit;
    logic [INT_W-1:0] intensity_floor;
    logic [MM_W-1:0]  far_value;
  } cfg_t;

endpackage

>>> hw/rtl/lbrf_beam_rule.sv
// ----------------------------------------------------------------------------
// lbrf_beam_rule: range rules for one beam
// Head, weak and edge rules in order; later rules override earlier ones.
// ----------------------------------------------------------------------------
module lbrf_beam_rule
  import lbrf_pkg::*;
(
  input  cfg_t            cfg,
  input  logic [MM_W-1:0] range_mm,
  input  logic [INT_W-1:0] intensity,
  input  logic            check_edge,
  input  logic [MM_W-1:0] prev_mm,
  input  logic [MM_W-1:0] next_mm,
  output logic [MM_W-1:0] filtered_mm
);

  logic [MM_W-1:0] gap_prev;
  logic [MM_W-1:0] gap_next;
  logic            near;

  assign gap_prev = (range_mm > prev_mm) ? range_mm - prev_mm : prev_mm - range_mm;
  assign gap_next = (range_mm > next_mm) ? range_mm - next_mm : next_mm - range_mm;
  assign near = range_mm < cfg.near_limit;

  always_comb begin
    filtered_mm = range_mm;
    if (range_mm < cfg.head_limit) begin
      filtered_mm = '0;
    end
    if (intensity < cfg.intensity_floor && near) begin
      filtered_mm = cfg.far_value;
    end
    if (check_edge && near &&
        (gap_prev > cfg.delta_threshold || gap_next > cfg.delta_threshold)) begin
      filtered_mm = cfg.far_value;
    end
  end

endmodule

>>> hw/rtl/lidar_beam_range_filter.sv
// ----------------------------------------------------------------------------
// lidar_beam_range_filter: planar lidar beam range filter, top level
// Three-beam window with head, weak-return and edge rules, queued results.
// ----------------------------------------------------------------------------
// The beam that completes a window (the held beam's next neighbour or, for the
//   last beam of a scan, the beam itself) waits in the input register, then its
//   results go to the result queue, the held beam's result first when there are two.
// Throughput: one beam per cycle while the result queue has room; a last beam
//   after a held beam pushes two results, which the single-read result queue hands out in turn.
// Reset (rst, synchronous, active high): no beam held, queue empty, registers at defaults.
module lidar_beam_range_filter
  import lbrf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // beam request channel
  input  logic                   beam_valid,
  output logic                   beam_ready,
  input  beam_t                  beam,
  // result request channel
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_threshold <= DELTA_THRESHOLD_RST;
      cfg.head_limit      <= HEAD_LIMIT_RST;
      cfg.near_limit      <= NEAR_LIMIT_RST;
      cfg.intensity_floor <= INTENSITY_FLOOR_RST;
      cfg.far_value       <= FAR_VALUE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELTA_THRESHOLD: cfg.delta_threshold <= cfg_data;
        REG_HEAD_LIMIT:      cfg.head_limit      <= cfg_data;
        REG_NEAR_LIMIT:      cfg.near_limit      <= cfg_data;
        REG_INTENSITY_FLOOR: cfg.intensity_floor <= cfg_data;
        REG_FAR_VALUE:       cfg.far_value       <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register: the newest beam, waiting to be filtered against the window
  // --------------------------------------------------------------------------
  logic  s1_valid;
  beam_t s1;
  logic  s1_adv;

  assign beam_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (beam_ready) begin
      s1_valid <= beam_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beam_valid && beam_ready) begin
      s1 <= beam;
    end
  end

  // --------------------------------------------------------------------------
  // Beam window: held beam (waits for its next neighbour) and the one before
  // --------------------------------------------------------------------------
  logic [MM_W-1:0]  held_range;
  logic [INT_W-1:0] held_intensity;
  logic [MM_W-1:0]  before_range;
  logic             held_valid;
  logic             held_is_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_range     <= '0;
      held_intensity <= '0;
      before_range   <= '0;
      held_valid     <= 1'b0;
      held_is_first  <= 1'b0;
    end else if (s1_adv) begin
      before_range   <= held_range;
      held_range     <= s1.range_mm;
      held_intensity <= s1.intensity;
      // a last beam closes the scan; otherwise it becomes the held beam
      held_valid     <= !s1.last_beam;
      held_is_first  <= !s1.last_beam && !held_valid;
    end
  end

  // held beam: edge rule unless it opened the scan; next neighbour is s1
  // new beam when last: no next neighbour, so never the edge rule
  logic [MM_W-1:0] held_mm;
  logic [MM_W-1:0] last_mm;

  lbrf_beam_rule u_held_rule (
    .cfg         (cfg),
    .range_mm    (held_range),
    .intensity   (held_intensity),
    .check_edge  (!held_is_first),
    .prev_mm     (before_range),
    .next_mm     (s1.range_mm),
    .filtered_mm (held_mm)
  );

  lbrf_beam_rule u_last_rule (
    .cfg         (cfg),
    .range_mm    (s1.range_mm),
    .intensity   (s1.intensity),
    .check_edge  (1'b0),
    .prev_mm     (held_range),
    .next_mm     ('0),
    .filtered_mm (last_mm)
  );

  // --------------------------------------------------------------------------
  // Result queue: up to two pushes, one pop per cycle
  // --------------------------------------------------------------------------
  result_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [1:0]          push_n;
  logic                pop;
  result_t             slot0;
  result_t             slot1;
  logic [QCNT_W:0]     fill_after;

  // results caused by the beam in s1: the held beam first, then a last beam
  assign push_n = s1_valid ? ({1'b0, held_valid} + {1'b0, s1.last_beam}) : 2'd0;
  assign pop = result_valid && result_ready;
  assign fill_after = {1'b0, count} + {{(QCNT_W - 1){1'b0}}, push_n};
  assign s1_adv = s1_valid &&
                  (fill_after <= (QCNT_W + 1)'(QUEUE_DEPTH) + {{QCNT_W{1'b0}}, pop});

  assign slot1 = '{filtered_mm: last_mm, scan_end: 1'b1};
  assign slot0 = held_valid ? '{filtered_mm: held_mm, scan_end: 1'b0} : slot1;

  always_ff @(posedge clk) begin
    if (s1_adv && push_n != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (s1_adv && push_n == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_adv) begin
        wr_ptr <= wr_ptr + QPTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= QCNT_W'(fill_after - (s1_adv ? '0 : {{(QCNT_W - 1){1'b0}}, push_n})
                       - {{QCNT_W{1'b0}}, pop});
    end
  end

  assign result_valid = count != '0;
  assign result = queue[rd_ptr];

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !pop |=> count == $past(count) + QCNT_W'($past(push_n)))
    else $error("queue count lost a push");

  a_scan_close: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.last_beam |=> !held_valid && !held_is_first)
    else $error("beam still held after scan end");

  a_first_held: assert property (@(posedge clk) disable iff (rst)
    held_is_first |-> held_valid)
    else $error("first-beam mark without a held beam");
`endif

endmodule

>>> tb/lidar_beam_range_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_beam_range_filter_tb: self-checking bench for the beam range filter
// Streams scans of beams through the block under several register settings.
// Every accepted beam is run through a cycle-free predictor. Every accepted
// result is compared in order against the predicted results. Both request
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module lidar_beam_range_filter_tb;
  import lbrf_pkg::*;

  localparam int unsigned CLK_HIGH_NS = 6;
  localparam int unsigned CLK_LOW_NS = 6;
  localparam int unsigned RESET_CYCLES = 7;
  // cycles without any accepted request before the run is declared hung
  localparam int unsigned STALL_LIMIT = 1000;
  // slack kept after the last predicted result has been taken
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES = 8;
  localparam int unsigned REG_COUNT = 5;
  localparam int unsigned BEAMS_PER_PHASE = 170;
  localparam logic [MM_W-1:0] MM_MAX = '1;

  // --------------------------------------------------------------------------
  // Predictor and in-order store of the expected filtered beams
  // --------------------------------------------------------------------------
  class beam_filter_board;
    cfg_t            cfg;
    logic [MM_W-1:0]  held_mm;
    logic [INT_W-1:0] held_int;
    logic [MM_W-1:0]  prior_mm;
    bit               holding;
    bit               held_first;
    result_t          due_results[$];
    int               errors;

    function new();
      cfg.delta_threshold = DELTA_THRESHOLD_RST;
      cfg.head_limit = HEAD_LIMIT_RST;
      cfg.near_limit = NEAR_LIMIT_RST;
      cfg.intensity_floor = INTENSITY_FLOOR_RST;
      cfg.far_value = FAR_VALUE_RST;
      held_mm = '0;
      held_int = '0;
      prior_mm = '0;
      holding = 1'b0;
      held_first = 1'b0;
      errors = 0;
    endfunction

    function logic [MM_W-1:0] jump(logic [MM_W-1:0] a, logic [MM_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // head, weak and edge rules in order; the later rule wins
    function logic [MM_W-1:0] filter_range(logic [MM_W-1:0] r, logic [INT_W-1:0] q,
                                           bit interior, logic [MM_W-1:0] prev,
                                           logic [MM_W-1:0] next);
      logic [MM_W-1:0] res;
      res = r;
      if (r < cfg.head_limit) res = '0;
      if (q < cfg.intensity_floor && r < cfg.near_limit) res = cfg.far_value;
      if (interior && r < cfg.near_limit &&
          (jump(r, prev) > cfg.delta_threshold || jump(r, next) > cfg.delta_threshold))
        res = cfg.far_value;
      return res;
    endfunction

    function void note_beam(beam_t b);
      result_t res;
      bit      starts;
      starts = !holding;
      if (holding) begin
        // the new beam is the next neighbour of the held one
        res.filtered_mm = filter_range(held_mm, held_int, !held_first, prior_mm,
                                       b.range_mm);
        res.scan_end = 1'b0;
        due_results.push_back(res);
      end
      if (b.last_beam) begin
        // no next neighbour: edge rule never applies
        res.filtered_mm = filter_range(b.range_mm, b.intensity, 1'b0, '0, '0);
        res.scan_end = 1'b1;
        due_results.push_back(res);
        holding = 1'b0;
        held_first = 1'b0;
      end else begin
        holding = 1'b1;
        held_first = starts;
      end
      prior_mm = held_mm;
      held_mm = b.range_mm;
      held_int = b.intensity;
    endfunction

    function void check_result(result_t r);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result filtered_mm=%0d scan_end=%0b",
                 $time, r.filtered_mm, r.scan_end);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (r.filtered_mm !== want.filtered_mm) begin
        $display("%0t: filtered_mm mismatch expected %0d actual %0d",
                 $time, want.filtered_mm, r.filtered_mm);
        errors++;
      end
      if (r.scan_end !== want.scan_end) begin
        $display("%0t: scan_end mismatch expected %0b actual %0b",
                 $time, want.scan_end, r.scan_end);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   beam_valid;
  logic                   beam_ready;
  beam_t                  beam;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lidar_beam_range_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .beam_valid   (beam_valid),
    .beam_ready   (beam_ready),
    .beam         (beam),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  beam_filter_board board = new();
  bit               steady;       // send_beam gaps and result stalls are zero
  logic [MM_W-1:0]  last_mm;      // range of the previous generated beam
  int unsigned      quiet_cycles;

  always begin
    clk = 1'b1;
    #(CLK_HIGH_NS);
    clk = 1'b0;
    #(CLK_LOW_NS);
  end

  // Watchdog: any accepted request on either channel restarts the count.
  always @(posedge clk) begin
    if ((beam_valid && beam_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("lidar_beam_range_filter_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall before each request, then hold ready until taken
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      board.check_result(result);
    end
  end

  // --------------------------------------------------------------------------
  // Beam side helpers
  // --------------------------------------------------------------------------
  // Random gap, then present the beam and keep it until accepted. Valid is
  // left high; a following send with no gap reuses it without a dip.
  task automatic send_beam(input beam_t b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      beam_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beam_valid <= 1'b1;
    beam <= b;
    @(posedge clk);
    while (!beam_ready) @(posedge clk);
    board.note_beam(b);
  endtask

  task automatic send(input logic [MM_W-1:0] r, input logic [INT_W-1:0] q, input bit last);
    beam_t b;
    b.range_mm = r;
    b.intensity = q;
    b.last_beam = last;
    send_beam(b);
  endtask

  // sender pauses until every predicted result has been taken
  task automatic hold_off();
    beam_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic drain(input int unsigned extra);
    while (board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Registers only change between scans with the block empty. Indexes past
  // the register list get junk that must be ignored.
  task automatic apply_settings(input cfg_t c);
    cfg_reg_t        regs[REG_COUNT];
    logic [MM_W-1:0] vals[REG_COUNT];
    regs = '{REG_DELTA_THRESHOLD, REG_HEAD_LIMIT, REG_NEAR_LIMIT,
             REG_INTENSITY_FLOOR, REG_FAR_VALUE};
    vals = '{c.delta_threshold, c.head_limit, c.near_limit,
             c.intensity_floor, c.far_value};
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    for (int i = int'(REG_FAR_VALUE) + 1; i < (1 << CFG_INDEX_W); i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_INDEX_W-1:0];
      cfg_data <= CFG_DATA_W'($urandom_range(0, 65535));
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    board.cfg = c;
    @(posedge clk);
  endtask

  function automatic logic [MM_W-1:0] clamp_mm(input int v);
    if (v < 0) return '0;
    if (v > int'(MM_MAX)) return MM_MAX;
    return v[MM_W-1:0];
  endfunction

  function automatic logic [MM_W-1:0] around(input logic [MM_W-1:0] center,
                                             input int spread);
    return clamp_mm(int'(center) + $urandom_range(0, 2 * spread) - spread);
  endfunction

  // Ranges cluster around the thresholds and the previous beam so that every
  // rule fires and misses by a hair; a share stays fully random.
  function automatic beam_t make_beam(input bit last);
    beam_t b;
    int    jumps;
    jumps = 2 * int'(board.cfg.delta_threshold) + 4;
    if (jumps > 4000) jumps = 4000;
    case ($urandom_range(0, 6))
      0: b.range_mm = MM_W'($urandom_range(0, 65535));
      1: b.range_mm = around(board.cfg.head_limit, 40);
      2: b.range_mm = around(board.cfg.near_limit, 40);
      3, 4: b.range_mm = around(last_mm, jumps);
      5: b.range_mm = $urandom_range(0, 1) ? MM_MAX : '0;
      default: b.range_mm = MM_W'($urandom_range(0, int'(board.cfg.near_limit)));
    endcase
    case ($urandom_range(0, 2))
      0: b.intensity = INT_W'($urandom_range(0, 65535));
      1: b.intensity = around(board.cfg.intensity_floor, 3);
      default: b.intensity = $urandom_range(0, 1) ? '1 : '0;
    endcase
    b.last_beam = last;
    last_mm = b.range_mm;
    return b;
  endfunction

  // Whole scans of random length; the phase always ends on a last beam.
  task automatic run_scans(input int beams);
    int sent;
    int len;
    sent = 0;
    while (sent < beams) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = 2;
        9: len = $urandom_range(20, 40);
        default: len = $urandom_range(3, 10);
      endcase
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 49) == 0) hold_off();
        send_beam(make_beam(k == len - 1));
        sent++;
      end
    end
    beam_valid <= 1'b0;
  endtask

  function automatic cfg_t mid_settings();
    cfg_t c;
    c.delta_threshold = MM_W'($urandom_range(0, 100));
    c.head_limit = MM_W'($urandom_range(0, 1000));
    c.near_limit = MM_W'($urandom_range(500, 4000));
    c.intensity_floor = INT_W'($urandom_range(0, 4000));
    c.far_value = MM_W'($urandom_range(0, 65535));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    rst = 1'b1;
    beam_valid = 1'b0;
    beam = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    last_mm = '0;
    quiet_cycles = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset defaults.
    // single-beam scans: zero range with zero intensity (head then weak),
    // and saturated range with full intensity (passes)
    send(16'd0, 16'd0, 1'b1);
    send(MM_MAX, 16'hFFFF, 1'b1);
    // first beam skips edge rule; interior jumps on either side hit the
    // edge rule; head, far and weak returns; last beam skips the edge rule
    send(16'd1000, 16'd5000, 1'b0);
    send(16'd1010, 16'd5000, 1'b0);
    send(16'd1100, 16'd5000, 1'b0);
    send(16'd1105, 16'hFFFF, 1'b0);
    send(16'd250, 16'd5000, 1'b0);
    send(16'd3000, 16'd100, 1'b0);
    send(16'd1500, 16'd1500, 1'b1);
    // head rule without near/weak interplay, weak return that is far
    send(16'd100, 16'd3000, 1'b0);
    send(16'd120, 16'd3000, 1'b0);
    send(16'd5000, 16'd0, 1'b1);
    // two-beam scan with the sender parked while the first beam is held
    send(16'd1999, 16'd1999, 1'b0);
    hold_off();
    send(16'd2000, 16'd2000, 1'b1);
    beam_valid <= 1'b0;
    drain(SETTLE_CYCLES);

    // everything zero: no rule can fire
    c = '0;
    apply_settings(c);
    run_scans(BEAMS_PER_PHASE);
    drain(SETTLE_CYCLES);

    // everything saturated: head rule almost always, weak rule mostly
    c = '1;
    apply_settings(c);
    run_scans(BEAMS_PER_PHASE);
    drain(SETTLE_CYCLES);

    // any jump counts as an edge; send_beam gaps and result stalls are zero
    c.delta_threshold = '0;
    c.head_limit = '0;
    c.near_limit = MM_MAX;
    c.intensity_floor = '0;
    c.far_value = 16'd12345;
    steady = 1'b1;
    apply_settings(c);
    run_scans(BEAMS_PER_PHASE);
    drain(SETTLE_CYCLES);
    steady = 1'b0;

    for (int p = 0; p < 2; p++) begin
      apply_settings(mid_settings());
      run_scans(BEAMS_PER_PHASE);
      drain(SETTLE_CYCLES);
    end

    // back to the reset values
    c.delta_threshold = DELTA_THRESHOLD_RST;
    c.head_limit = HEAD_LIMIT_RST;
    c.near_limit = NEAR_LIMIT_RST;
    c.intensity_floor = INTENSITY_FLOOR_RST;
    c.far_value = FAR_VALUE_RST;
    apply_settings(c);
    run_scans(BEAMS_PER_PHASE);

    drain(END_CYCLES);
    if (board.errors == 0) begin
      $display("lidar_beam_range_filter_tb passed");
    end else begin
      $display("lidar_beam_range_filter_tb failed");
    end
    $finish;
  end

endmodule
